// ===== rtl/json_string_unescape_utf8_unit_defines.svh =====
// assertion macros shared by the unescape unit rtl
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

// same-cycle implication, checks off while in reset
`define JSU_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checks off while in reset
`define JSU_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// shared types, constants and helper functions of the unescape unit
package jsu_pkg;

  localparam int MaxResults = 8;
  localparam int IdxW       = $clog2(MaxResults);
  localparam int CountW     = $clog2(MaxResults + 1);

  // decoder modes
  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeText     = 3'd1,
    ModeEsc      = 3'd2,
    ModeHex      = 3'd3,
    ModeHighWait = 3'd4,
    ModeHighBs   = 3'd5,
    ModeLowHex   = 3'd6
  } mode_e;

  // characters
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  // surrogate ranges and utf-8 framing
  localparam logic [15:0] SurrHighMin = 16'hD800;
  localparam logic [15:0] SurrHighMax = 16'hDBFF;
  localparam logic [15:0] SurrLowMin  = 16'hDC00;
  localparam logic [15:0] SurrLowMax  = 16'hDFFF;
  localparam logic [20:0] PairBase    = 21'h10000;
  localparam logic [7:0]  Utf8Lead2   = 8'hC0;
  localparam logic [7:0]  Utf8Lead3   = 8'hE0;
  localparam logic [7:0]  Utf8Lead4   = 8'hF0;
  localparam logic [7:0]  Utf8Cont    = 8'h80;
  localparam logic [7:0]  Utf8Mask    = 8'h3F;

  // one raw input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_string;
    logic       end_of_body;
  } item_t;

  // all result words caused by one input word
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       last;
    logic                       marker;
  } group_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r.valid = 1'b1;
    r.val   = c[3:0];
    if (c inside {[ChZero:ChNine]}) begin
      r.val = c[3:0];
    end else if (c inside {[ChLowA:ChLowF], [ChUpA:ChUpF]}) begin
      r.val = c[3:0] + 4'd9;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] c);
    utf8_t r;
    r = '0;
    if (c < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = c[7:0];
    end else if (c < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = Utf8Lead2 | {3'd0, c[10:6]};
      r.b[1] = Utf8Cont | (Utf8Mask & {2'd0, c[5:0]});
    end else if (c < 21'h10000) begin
      r.len  = 3'd3;
      r.b[0] = Utf8Lead3 | {4'd0, c[15:12]};
      r.b[1] = Utf8Cont | (Utf8Mask & {2'd0, c[11:6]});
      r.b[2] = Utf8Cont | (Utf8Mask & {2'd0, c[5:0]});
    end else begin
      r.len  = 3'd4;
      r.b[0] = Utf8Lead4 | {5'd0, c[20:18]};
      r.b[1] = Utf8Cont | (Utf8Mask & {2'd0, c[17:12]});
      r.b[2] = Utf8Cont | (Utf8Mask & {2'd0, c[11:6]});
      r.b[3] = Utf8Cont | (Utf8Mask & {2'd0, c[5:0]});
    end
    return r;
  endfunction

  function automatic group_t grp_push(input group_t g, input logic [7:0] c);
    group_t r;
    r = g;
    if (r.count < CountW'(MaxResults)) begin
      r.bytes[r.count[IdxW-1:0]] = c;
      r.count = r.count + CountW'(1);
    end
    return r;
  endfunction

  function automatic group_t grp_push_code(input group_t g, input utf8_t u);
    group_t r;
    r = g;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < u.len) begin
        r = grp_push(r, u.b[k]);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/jsu_in_if.sv =====
// input channel: raw string body words
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_string;
  logic       end_of_body;

  modport source (output valid, data_byte, start_string, end_of_body, input ready);
  modport sink (input valid, data_byte, start_string, end_of_body, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// output channel: decoded utf-8 words
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, out_byte, byte_valid, last, input ready);
  modport sink (input valid, out_byte, byte_valid, last, output ready);
endinterface

// ===== rtl/jsu_decoder.sv =====
// escape decoder: mode state plus single-pass expansion of one word into a result group
module jsu_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  jsu_pkg::item_t   item_i,
  output jsu_pkg::group_t  grp_o
);
  import jsu_pkg::*;
  `include "json_string_unescape_utf8_unit_defines.svh"

  mode_e       mode_q, mode_d, mode_s;
  logic [11:0] acc_q, acc_d, acc_s;
  logic [1:0]  dc_q, dc_d, dc_s;
  logic [9:0]  high_q, high_d, high_s;
  logic [7:0]  held_q [3];
  logic        held_we;
  logic [1:0]  held_idx;

  logic [7:0]  b;
  logic        fin;
  hex_t        hx;
  logic [15:0] code_v;
  logic        go_text, go_esc, go_hex, put_high, over, active;
  group_t      g;

  assign b      = item_i.data_byte;
  assign fin    = item_i.end_of_body;
  assign hx     = hex_value(b);

  // start of a string clears everything but the held digits
  assign mode_s = item_i.start_string ? ModeText : mode_q;
  assign acc_s  = item_i.start_string ? '0 : acc_q;
  assign dc_s   = item_i.start_string ? '0 : dc_q;
  assign high_s = item_i.start_string ? '0 : high_q;
  assign code_v = {acc_s, hx.val};

  always_comb begin
    mode_d   = mode_s;
    acc_d    = acc_s;
    dc_d     = dc_s;
    high_d   = high_s;
    held_we  = 1'b0;
    held_idx = dc_s;
    go_text  = 1'b0;
    go_esc   = 1'b0;
    go_hex   = 1'b0;
    put_high = 1'b0;
    over     = 1'b0;
    active   = 1'b1;
    g        = '0;

    case (mode_s)
      ModeText: go_text = 1'b1;
      ModeEsc:  go_esc  = 1'b1;
      ModeHex:  go_hex  = 1'b1;
      ModeHighWait: begin
        if (b == ChBackslash && !fin) begin
          mode_d = ModeHighBs;
        end else begin
          put_high = 1'b1;
          go_text  = 1'b1;
        end
      end
      ModeHighBs: begin
        if (b == ChU && !fin) begin
          mode_d = ModeLowHex;
          dc_d   = '0;
          acc_d  = '0;
        end else begin
          put_high = 1'b1;
          go_esc   = 1'b1;
        end
      end
      ModeLowHex: begin
        if (hx.valid && dc_s == 2'd3) begin
          if (code_v >= SurrLowMin && code_v <= SurrLowMax) begin
            g      = grp_push_code(g, utf8_encode(PairBase + {1'b0, high_s, code_v[9:0]}));
            dc_d   = '0;
            acc_d  = '0;
            mode_d = ModeText;
          end else begin
            put_high = 1'b1;
            go_hex   = 1'b1;
            mode_d   = ModeHex;
          end
        end else if (hx.valid && !fin) begin
          held_we = 1'b1;
          acc_d   = {acc_s[7:0], hx.val};
          dc_d    = dc_s + 2'd1;
        end else begin
          put_high = 1'b1;
          go_hex   = 1'b1;
          mode_d   = ModeHex;
        end
      end
      default: begin
        mode_d = ModeIdle;
        active = 1'b0;
      end
    endcase

    // pending high surrogate that found no partner
    if (put_high) begin
      g = grp_push_code(g, utf8_encode({5'd0, SurrHighMin | {6'd0, high_s}}));
    end

    if (go_hex) begin
      if (hx.valid && !(fin && dc_s != 2'd3)) begin
        if (dc_s == 2'd3) begin
          dc_d   = '0;
          acc_d  = '0;
          mode_d = ModeText;
          if (code_v >= SurrHighMin && code_v <= SurrHighMax && !fin) begin
            high_d = code_v[9:0];
            mode_d = ModeHighWait;
          end else begin
            g = grp_push_code(g, utf8_encode({5'd0, code_v}));
          end
        end else begin
          held_we = 1'b1;
          acc_d   = {acc_s[7:0], hx.val};
          dc_d    = dc_s + 2'd1;
        end
      end else begin
        // broken escape: replay it literally, then treat the byte as text
        g = grp_push(g, ChU);
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < dc_s) begin
            g = grp_push(g, held_q[k]);
          end
        end
        dc_d    = '0;
        acc_d   = '0;
        go_text = 1'b1;
      end
    end

    if (go_text) begin
      mode_d = ModeText;
      if (b == ChQuote) begin
        over = 1'b1;
      end else if (b == ChBackslash && !fin) begin
        mode_d = ModeEsc;
      end else begin
        g = grp_push(g, b);
      end
    end

    if (go_esc) begin
      mode_d = ModeText;
      case (b)
        ChN: g = grp_push(g, ChLf);
        ChR: g = grp_push(g, ChCr);
        ChT: g = grp_push(g, ChTab);
        ChB: g = grp_push(g, ChBs);
        ChF: g = grp_push(g, ChFf);
        ChU: begin
          if (fin) begin
            g = grp_push(g, ChU);
          end else begin
            mode_d = ModeHex;
            dc_d   = '0;
            acc_d  = '0;
          end
        end
        default: g = grp_push(g, b);
      endcase
    end

    // string end: mark the final word, or send a bare end marker
    if (active && (fin || over)) begin
      mode_d = ModeIdle;
      acc_d  = '0;
      dc_d   = '0;
      high_d = '0;
      if (g.count == '0) begin
        g.marker = 1'b1;
        g.count  = CountW'(1);
        g.bytes  = '0;
      end
      g.last = 1'b1;
    end

    grp_o = g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q  <= '0;
      dc_q   <= '0;
      high_q <= '0;
    end else if (adv_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      dc_q   <= dc_d;
      high_q <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && held_we) begin
      held_q[held_idx] <= b;
    end
  end

  `JSU_ASSERT_NXT(a_end_goes_idle, clk_i, rst_ni, adv_i && item_i.end_of_body, mode_q == ModeIdle, "end of body did not return decoder to idle")
  `JSU_ASSERT_IMP(a_idle_silent, clk_i, rst_ni, adv_i && mode_q == ModeIdle && !item_i.start_string, grp_o.count == '0, "word outside a string produced output")

endmodule

// ===== rtl/jsu_burst_out.sv =====
// result register: holds one group and hands its words out one per cycle while the output is ready
module jsu_burst_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jsu_pkg::group_t  grp_i,
  output logic             free_o,
  jsu_out_if.source        out_o
);
  import jsu_pkg::*;
  `include "json_string_unescape_utf8_unit_defines.svh"

  logic [MaxResults-1:0][7:0] bytes_q;
  logic [CountW-1:0]          rem_q;
  logic                       last_q, marker_q;
  logic                       pop;

  assign out_o.valid      = (rem_q != '0);
  assign out_o.out_byte   = bytes_q[0];
  assign out_o.byte_valid = !marker_q;
  assign out_o.last       = last_q && (rem_q == CountW'(1));
  assign pop              = out_o.valid && out_o.ready;

  // free now, or the final word leaves this cycle
  assign free_o = (rem_q == '0) || (rem_q == CountW'(1) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      last_q   <= 1'b0;
      marker_q <= 1'b0;
    end else if (load_i) begin
      rem_q    <= grp_i.count;
      last_q   <= grp_i.last;
      marker_q <= grp_i.marker;
    end else if (pop) begin
      rem_q <= rem_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[MaxResults-1:1]};
    end
  end

  `JSU_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, load_i, rem_q == '0 || (rem_q == CountW'(1) && out_o.ready), "group loaded over undelivered words")
  `JSU_ASSERT_NXT(a_pop_counts, clk_i, rst_ni, pop && !load_i, rem_q == $past(rem_q) - CountW'(1), "word count did not drop on delivery")
  `JSU_ASSERT_IMP(a_marker_single, clk_i, rst_ni, load_i && grp_i.marker, grp_i.count == CountW'(1) && grp_i.last, "end marker group is not a single final word")

endmodule

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// top level of the json string unescaper with utf-8 output
// path: a taken word waits in the input register, then its results are loaded into
//   the result register, which hands them to the output; either step can stall
// throughput: one input word per cycle while each word yields at most one result and
//   the output is ready; a multi-result word holds the result register until all leave
// reset: decoder idle outside any string, both stages empty, held hex digits kept
module json_string_unescape_utf8_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // input register stage
  logic   stg_valid_q;
  item_t  stg_q;
  logic   adv;        // staged word moves into the decoder and result register
  logic   out_free;   // result register can take a new group this cycle
  logic   in_take;
  group_t grp;

  assign adv       = stg_valid_q && out_free;
  assign in_i.ready = !stg_valid_q || adv;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_take) begin
      stg_valid_q <= 1'b1;
    end else if (adv) begin
      stg_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      stg_q.data_byte    <= in_i.data_byte;
      stg_q.start_string <= in_i.start_string;
      stg_q.end_of_body  <= in_i.end_of_body;
    end
  end

  // decoder state updates only when the staged word is consumed
  jsu_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (stg_q),
    .grp_o  (grp)
  );

  // an empty group loads as zero words and leaves the output idle
  jsu_burst_out u_burst_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (adv),
    .grp_i  (grp),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the json string unescape unit with utf-8 output
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // one decoded word as seen on the output channel
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } utf8_word_t;

  // directed stimulus: an input word, optionally with its single result typed in
  typedef struct packed {
    item_t      word;
    logic       typed;
    utf8_word_t want;
  } stim_row_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int          ItemTarget = 410;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // idle rates in percent, changed by the stimulus phases
  int send_idle = 0;
  int recv_idle = 0;

  int          n_errors = 0;
  int unsigned cycle_count = 0;

  // decoder mirror: mode, gathered hex value, digit count, pending high surrogate
  mode_e       dec_mode;
  logic [15:0] dec_accum;
  logic [2:0]  dec_count;
  logic [9:0]  dec_high;
  logic [7:0]  dec_held [3];
  logic [7:0]  step_bytes [$];
  logic        step_closes;

  utf8_word_t  step_words [$];
  utf8_word_t  utf8_expected [$];
  utf8_word_t  head_word;

  item_t       body_q [$];
  stim_row_t   dir_rows [$];

  // ---------------------------------------------------------------------------
  // decoder mirror
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_mode  = ModeIdle;
    dec_accum = '0;
    dec_count = '0;
    dec_high  = '0;
  endfunction

  // at most eight bytes leave the block per input word
  function automatic void emit_byte(input logic [7:0] b);
    if (step_bytes.size() < MaxResults) step_bytes.insert(step_bytes.size(), b);
  endfunction

  function automatic void emit_code(input logic [20:0] c);
    if (c < 21'h80) begin
      emit_byte(c[7:0]);
    end else if (c < 21'h800) begin
      emit_byte(Utf8Lead2 | {3'b0, c[10:6]});
      emit_byte(Utf8Cont | {2'b0, c[5:0]});
    end else if (c < 21'h10000) begin
      emit_byte(Utf8Lead3 | {4'b0, c[15:12]});
      emit_byte(Utf8Cont | {2'b0, c[11:6]});
      emit_byte(Utf8Cont | {2'b0, c[5:0]});
    end else begin
      emit_byte(Utf8Lead4 | {5'b0, c[20:18]});
      emit_byte(Utf8Cont | {2'b0, c[17:12]});
      emit_byte(Utf8Cont | {2'b0, c[11:6]});
      emit_byte(Utf8Cont | {2'b0, c[5:0]});
    end
  endfunction

  // pending high surrogate given up, goes out alone in three bytes
  function automatic void flush_high();
    emit_code({5'b0, SurrHighMin + {6'b0, dec_high}});
  endfunction

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= ChZero && b <= ChNine) return int'(b - ChZero);
    if (b >= ChLowA && b <= ChLowF) return int'(b - ChLowA) + 10;
    if (b >= ChUpA && b <= ChUpF) return int'(b - ChUpA) + 10;
    return -1;
  endfunction

  function automatic void take_text(input logic [7:0] b, input logic fin);
    dec_mode = ModeText;
    if (b == ChQuote) begin
      step_closes = 1'b1;
    end else if (b == ChBackslash && !fin) begin
      dec_mode = ModeEsc;
    end else begin
      emit_byte(b);
    end
  endfunction

  function automatic void take_escape(input logic [7:0] b, input logic fin);
    dec_mode = ModeText;
    case (b)
      ChN: emit_byte(ChLf);
      ChR: emit_byte(ChCr);
      ChT: emit_byte(ChTab);
      ChB: emit_byte(ChBs);
      ChF: emit_byte(ChFf);
      ChU: begin
        // \u on the last byte has no digits to come
        if (fin) begin
          emit_byte(ChU);
        end else begin
          dec_mode  = ModeHex;
          dec_count = '0;
          dec_accum = '0;
        end
      end
      default: emit_byte(b);
    endcase
  endfunction

  function automatic void take_hex(input logic [7:0] b, input logic fin);
    int          h;
    int          k;
    logic [15:0] v;
    h = nibble_of(b);
    if (h >= 0 && !(fin && dec_count < 3)) begin
      if (dec_count >= 3) begin
        v = {dec_accum[11:0], 4'(h)};
        dec_count = '0;
        dec_accum = '0;
        dec_mode  = ModeText;
        if (v >= SurrHighMin && v <= SurrHighMax && !fin) begin
          dec_high = v[9:0];
          dec_mode = ModeHighWait;
        end else begin
          emit_code({5'b0, v});
        end
      end else begin
        dec_held[dec_count[1:0]] = b;
        dec_accum = {dec_accum[11:0], 4'(h)};
        dec_count++;
      end
      return;
    end
    // short or broken escape: replay it literally, then treat the byte as text
    emit_byte(ChU);
    for (k = 0; k < dec_count && k < 3; k++) emit_byte(dec_held[k]);
    dec_count = '0;
    dec_accum = '0;
    take_text(b, fin);
  endfunction

  function automatic void take_low_hex(input logic [7:0] b, input logic fin);
    int          h;
    logic [15:0] v;
    h = nibble_of(b);
    if (h >= 0 && dec_count >= 3) begin
      v = {dec_accum[11:0], 4'(h)};
      if (v >= SurrLowMin && v <= SurrLowMax) begin
        emit_code(PairBase + 21'({dec_high, v[9:0]}));
        dec_count = '0;
        dec_accum = '0;
        dec_mode  = ModeText;
        return;
      end
    end else if (h >= 0 && !fin) begin
      dec_held[dec_count[1:0]] = b;
      dec_accum = {dec_accum[11:0], 4'(h)};
      dec_count++;
      return;
    end
    // no valid low half: high goes out alone, the second \u is decoded afresh
    flush_high();
    dec_mode = ModeHex;
    take_hex(b, fin);
  endfunction

  // works out the words that one accepted input word causes, into step_words
  function automatic void decode_word(input item_t w);
    logic       closes;
    utf8_word_t wd;
    step_bytes.delete();
    step_words.delete();
    step_closes = 1'b0;
    if (w.start_string) begin
      clear_decoder();
      dec_mode = ModeText;
    end
    case (dec_mode)
      ModeText:     take_text(w.data_byte, w.end_of_body);
      ModeEsc:      take_escape(w.data_byte, w.end_of_body);
      ModeHex:      take_hex(w.data_byte, w.end_of_body);
      ModeHighWait: begin
        if (w.data_byte == ChBackslash && !w.end_of_body) begin
          dec_mode = ModeHighBs;
        end else begin
          flush_high();
          take_text(w.data_byte, w.end_of_body);
        end
      end
      ModeHighBs: begin
        if (w.data_byte == ChU && !w.end_of_body) begin
          dec_mode  = ModeLowHex;
          dec_count = '0;
          dec_accum = '0;
        end else begin
          flush_high();
          take_escape(w.data_byte, w.end_of_body);
        end
      end
      ModeLowHex:   take_low_hex(w.data_byte, w.end_of_body);
      default: begin
        // outside any string: the word is dropped
        dec_mode = ModeIdle;
        return;
      end
    endcase
    closes = w.end_of_body || step_closes;
    if (closes) clear_decoder();
    // a string that ends with no data byte still gets an end marker
    if (closes && step_bytes.size() == 0) begin
      wd = '{8'h00, 1'b0, 1'b1};
      step_words.insert(step_words.size(), wd);
    end
    foreach (step_bytes[k]) begin
      wd.out_byte   = step_bytes[k];
      wd.byte_valid = 1'b1;
      wd.last       = closes && (k == step_bytes.size() - 1);
      step_words.insert(step_words.size(), wd);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // random string bodies
  // ---------------------------------------------------------------------------

  function automatic void push_byte(input logic [7:0] b);
    item_t w;
    w = '{b, 1'b0, 1'b0};
    body_q.insert(body_q.size(), w);
  endfunction

  // any byte that neither ends the string nor opens an escape
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChQuote || b == ChBackslash);
    return b;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(9))
      0:       return ChN;
      1:       return ChR;
      2:       return ChT;
      3:       return ChB;
      4:       return ChF;
      5:       return ChQuote;
      6:       return ChBackslash;
      7:       return 8'h2F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // hex digit in either case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ChZero + 8'(n);
    return (($urandom_range(1) != 0) ? ChLowA : ChUpA) + 8'(n - 4'd10);
  endfunction

  function automatic logic [9:0] tail10();
    case ($urandom_range(3))
      0:       return 10'h000;
      1:       return 10'h3FF;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  // code classes: zero, one to three utf-8 bytes, extremes, both surrogate halves
  function automatic logic [15:0] random_code();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'($urandom_range(16'h0001, 16'h007F));
      2:       return 16'($urandom_range(16'h0080, 16'h07FF));
      3:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      4:       return 16'hFFFF;
      5:       return SurrHighMin + {6'b0, tail10()};
      6:       return SurrLowMin + {6'b0, tail10()};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_uesc(input logic [15:0] v);
    push_byte(ChBackslash);
    push_byte(ChU);
    for (int k = 3; k >= 0; k--) push_byte(hex_char(v[4*k +: 4]));
  endfunction

  // \u with fewer than four digits, broken by a non-hex byte
  function automatic void push_broken_u();
    logic [7:0] b;
    push_byte(ChBackslash);
    push_byte(ChU);
    repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(15))));
    do b = 8'($urandom_range(255)); while (nibble_of(b) >= 0);
    push_byte(b);
  endfunction

  // one string: a few tokens, then a quote, a cut with end_of_body, or no end
  function automatic void build_string();
    int    kind;
    int    cut;
    item_t w;
    body_q.delete();
    repeat ($urandom_range(0, 6)) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        push_byte(plain_byte());
      end else if (kind < 50) begin
        push_byte(ChBackslash);
        push_byte(escape_letter());
      end else if (kind < 65) begin
        push_uesc(random_code());
      end else if (kind < 80) begin
        push_uesc(SurrHighMin + {6'b0, tail10()});
        push_uesc(SurrLowMin + {6'b0, tail10()});
      end else if (kind < 90) begin
        push_broken_u();
      end else begin
        // high surrogate, then text, an escape, any \u or a broken \u
        push_uesc(SurrHighMin + {6'b0, tail10()});
        case ($urandom_range(3))
          0: push_byte(plain_byte());
          1: begin
            push_byte(ChBackslash);
            push_byte(escape_letter());
          end
          2: push_uesc(random_code());
          default: push_broken_u();
        endcase
      end
    end
    kind = $urandom_range(99);
    if (kind < 50) begin
      push_byte(ChQuote);
      if ($urandom_range(4) == 0) begin
        w = body_q.pop_back();
        w.end_of_body = 1'b1;
        body_q.insert(body_q.size(), w);
      end
    end else if (kind < 85) begin
      // body cut anywhere, also inside an escape
      if (body_q.size() == 0) push_byte(plain_byte());
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
      w = body_q.pop_back();
      w.end_of_body = 1'b1;
      body_q.insert(body_q.size(), w);
    end
    if (body_q.size() > 0) begin
      w = body_q.pop_front();
      w.start_string = 1'b1;
      body_q.push_front(w);
    end
  endfunction

  // appends one directed row to the stimulus table
  function automatic void add_row(input logic [7:0] b, input logic s, input logic f,
                                  input logic typed, input utf8_word_t want);
    stim_row_t r;
    r.word  = '{b, s, f};
    r.typed = typed;
    r.want  = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // offers one word, waits for it to be taken, then records what it must cause
  task automatic send_word(input item_t w, input logic typed, input utf8_word_t want);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= w.data_byte;
    in_ch.start_string <= w.start_string;
    in_ch.end_of_body  <= w.end_of_body;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    decode_word(w);
    if (typed) begin
      utf8_expected.insert(utf8_expected.size(), want);
    end else begin
      foreach (step_words[k]) utf8_expected.insert(utf8_expected.size(), step_words[k]);
    end
  endtask

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // compare every accepted output word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (utf8_expected.size() == 0) begin
        $error("word with nothing expected: out_byte %h byte_valid %b last %b",
               out_ch.out_byte, out_ch.byte_valid, out_ch.last);
        n_errors++;
      end else begin
        head_word = utf8_expected.pop_front();
        if (out_ch.out_byte !== head_word.out_byte) begin
          $error("out_byte: expected %h, got %h", head_word.out_byte, out_ch.out_byte);
          n_errors++;
        end
        if (out_ch.byte_valid !== head_word.byte_valid) begin
          $error("byte_valid: expected %b, got %b", head_word.byte_valid, out_ch.byte_valid);
          n_errors++;
        end
        if (out_ch.last !== head_word.last) begin
          $error("last: expected %b, got %b", head_word.last, out_ch.last);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int words_sent;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.start_string = 1'b0;
    in_ch.end_of_body  = 1'b0;
    clear_decoder();
    foreach (dec_held[k]) dec_held[k] = '0;

    // directed part: idle drop, byte extremes, an escape, code zero, lone high
    // surrogate closed by a quote, trailing backslash, empty string, short \u at
    // the end of the body, then a byte after the string is over
    add_row("x",         1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00,       1'b1, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0});
    add_row(8'hFF,       1'b0, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0});
    add_row(ChBackslash, 1'b0, 1'b0, 1'b0, '0);
    add_row(ChN,         1'b0, 1'b0, 1'b1, '{ChLf, 1'b1, 1'b0});
    add_row(ChBackslash, 1'b0, 1'b0, 1'b0, '0);
    add_row(ChU,         1'b0, 1'b0, 1'b0, '0);
    add_row("0",         1'b0, 1'b0, 1'b0, '0);
    add_row("0",         1'b0, 1'b0, 1'b0, '0);
    add_row("0",         1'b0, 1'b0, 1'b0, '0);
    add_row("0",         1'b0, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0});
    add_row(ChBackslash, 1'b0, 1'b0, 1'b0, '0);
    add_row(ChU,         1'b0, 1'b0, 1'b0, '0);
    add_row("D",         1'b0, 1'b0, 1'b0, '0);
    add_row("8",         1'b0, 1'b0, 1'b0, '0);
    add_row("3",         1'b0, 1'b0, 1'b0, '0);
    add_row("D",         1'b0, 1'b0, 1'b0, '0);
    add_row(ChQuote,     1'b0, 1'b0, 1'b0, '0);
    add_row(ChBackslash, 1'b1, 1'b1, 1'b1, '{ChBackslash, 1'b1, 1'b1});
    add_row(ChQuote,     1'b1, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1});
    add_row(ChBackslash, 1'b1, 1'b0, 1'b0, '0);
    add_row(ChU,         1'b0, 1'b0, 1'b0, '0);
    add_row("a",         1'b0, 1'b0, 1'b0, '0);
    add_row("F",         1'b0, 1'b1, 1'b0, '0);
    add_row("y",         1'b0, 1'b0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle = 34;
    recv_idle = 49;
    foreach (dir_rows[k]) send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
    words_sent = dir_rows.size();

    // random strings; idle rates swap after a third, then both sides run flat out
    while (words_sent < ItemTarget) begin
      if (words_sent < ItemTarget / 3) begin
        send_idle = 34;
        recv_idle = 49;
      end else if (words_sent < 2 * ItemTarget / 3) begin
        send_idle = 49;
        recv_idle = 34;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // stray bytes between strings, dropped unless a string is still open
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_word('{8'($urandom_range(255)), 1'b0, 1'b0}, 1'b0, '0);
          words_sent++;
        end
      end
      build_string();
      foreach (body_q[k]) send_word(body_q[k], 1'b0, '0);
      words_sent += body_q.size();
    end
    in_ch.valid <= 1'b0;

    // drain, then keep watching the output for anything unexpected to show up
    while (utf8_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
